// ----- sv/triangle_primitive_assembler_unit_assert.svh -----
// Assertion macros for the triangle primitive assembler.
// Included by the top level; no other dependencies.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_UNIT_ASSERT_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked check, held off while reset is low.
`define TPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");
// Clocked check that also holds during reset.
`define TPA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");
`else
`define TPA_ASSERT(lbl, clk, rst_n, prop)
`define TPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/tpa_pkg.sv -----
// Shared types, codes and sizes of the triangle primitive assembler.
// No dependencies; imported by the top level and the element unit.
package tpa_pkg;

    localparam int INDEX_WORDS = 1024;
    localparam int ADDR_W      = $clog2(INDEX_WORDS);
    localparam int POS_W       = 16;
    localparam int CAP_W       = POS_W + 1;
    localparam logic [CAP_W-1:0] INDEX_WORDS_CAP = CAP_W'(INDEX_WORDS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEXED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 3'd4;

    localparam logic [1:0] TOPO_LIST    = 2'd0;
    localparam logic [1:0] TOPO_STRIP   = 2'd1;
    localparam logic [1:0] TOPO_FAN     = 2'd2;
    localparam logic [1:0] TOPO_INVALID = 2'd3;

    localparam logic [1:0] WIDTH_BYTE    = 2'd0;
    localparam logic [1:0] WIDTH_HALF    = 2'd1;
    localparam logic [1:0] WIDTH_WORD    = 2'd2;
    localparam logic [1:0] WIDTH_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOB  = 2'd1;
    localparam logic [1:0] ST_TOPO = 2'd2;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_ASSEMBLE = 1'b1;

    typedef struct packed {
        logic [1:0]  topology;
        logic        indexed;
        logic [1:0]  index_width;
        logic [15:0] index_count;
        logic [31:0] vertex_count;
    } t_cfg;

endpackage

// ----- sv/triangle_primitive_assembler_unit.sv -----
// Triangle primitive assembler over a packed index store; uses tpa_pkg, tpa_index_ram,
// tpa_elem_unit and the assertion macro header.
// A load word is written to the index store on accept. An assemble word runs three element steps,
// one per cycle, each reading the single-port index RAM when indexed, then a drain step and the
// output load, which waits while the result channel stalls; topology or count errors skip the reads.
// No new word is taken until the result is loaded. Reset: synchronous, active low.
`include "triangle_primitive_assembler_unit_assert.svh"
module triangle_primitive_assembler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [9:0]                     i_word_address,
    input  logic [31:0]                    i_word_data,
    input  logic [15:0]                    i_triangle_number,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_vertex_first,
    output logic [31:0]                    o_vertex_second,
    output logic [31:0]                    o_vertex_third,
    output logic [1:0]                     o_status
);
    import tpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Config registers; reset: list, word width, rest zero; index store left undefined.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.topology     <= TOPO_LIST;
            r_cfg.indexed      <= 1'b0;
            r_cfg.index_width  <= WIDTH_WORD;
            r_cfg.index_count  <= 16'd0;
            r_cfg.vertex_count <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOPOLOGY:     r_cfg.topology     <= i_cfg_data[1:0];
                CFG_INDEXED:      r_cfg.indexed      <= i_cfg_data[0];
                CFG_INDEX_WIDTH:  r_cfg.index_width  <= i_cfg_data[1:0];
                CFG_INDEX_COUNT:  r_cfg.index_count  <= i_cfg_data[15:0];
                CFG_VERTEX_COUNT: r_cfg.vertex_count <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output registers.
    t_state            r_state, n_state;
    logic [1:0]        r_step, n_step;
    logic [POS_W-1:0]  r_base, n_base;       // first position of the triangle (list/strip)
    logic [POS_W-1:0]  r_prev_pos, n_prev_pos;
    logic              r_swap, n_swap;       // odd strip triangle
    logic              r_err, n_err;         // capacity or vertex bound failure
    logic [1:0]        r_status, n_status;   // early status from accept checks
    logic [31:0]       r_v [3];
    logic [31:0]       n_v [3];

    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_v0, n_out_v0;
    logic [31:0]       r_out_v1, n_out_v1;
    logic [31:0]       r_out_v2, n_out_v2;
    logic [1:0]        r_out_status, n_out_status;

    logic              accept;
    logic [POS_W+1:0]  acc_base;
    logic [POS_W+1:0]  acc_last;
    logic [POS_W-1:0]  issue_pos;
    logic [POS_W-1:0]  issue_waddr;
    logic              issue_fetch;
    logic              load_we;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_rdata;
    logic [31:0]       elem;
    logic              elem_oob;
    logic [1:0]        final_status;
    logic              out_free;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Accept-time positions: list starts at 3t, strip and fan at t.
    assign acc_base = (r_cfg.topology == TOPO_LIST)
                    ? ({2'b00, i_triangle_number} + {1'b0, i_triangle_number, 1'b0})
                    : {2'b00, i_triangle_number};
    assign acc_last = acc_base + (POS_W+2)'(2);

    // Position of the element read this step; fan pins the first one to zero.
    assign issue_pos = (r_cfg.topology == TOPO_FAN && r_step == 2'd0)
                     ? '0 : r_base + POS_W'(r_step);

    always_comb begin
        case (r_cfg.index_width)
            WIDTH_BYTE: issue_waddr = issue_pos >> 2;
            WIDTH_HALF: issue_waddr = issue_pos >> 1;
            default:    issue_waddr = issue_pos;
        endcase
    end

    assign issue_fetch = r_cfg.indexed && (r_cfg.index_width != WIDTH_UNKNOWN);

    // Single RAM port: loads in idle, element reads while running.
    assign load_we = accept && (i_mode == MODE_LOAD)
                  && ({{(CAP_W-10){1'b0}}, i_word_address} < INDEX_WORDS_CAP);
    assign ram_we  = load_we;
    assign ram_re  = (r_state == S_RUN) && (r_step != 2'd3) && issue_fetch
                  && ({1'b0, issue_waddr} < INDEX_WORDS_CAP);
    assign ram_addr = (r_state == S_IDLE) ? ADDR_W'(i_word_address) : ADDR_W'(issue_waddr);

    tpa_index_ram #(
        .DEPTH (INDEX_WORDS),
        .WIDTH (32)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_word_data),
        .o_rdata (ram_rdata)
    );

    tpa_elem_unit u_elem (
        .i_cfg  (r_cfg),
        .i_word (ram_rdata),
        .i_pos  (r_prev_pos),
        .o_elem (elem),
        .o_oob  (elem_oob)
    );

    assign final_status = (r_status != ST_OK) ? r_status : (r_err ? ST_OOB : ST_OK);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_base       = r_base;
        n_prev_pos   = r_prev_pos;
        n_swap       = r_swap;
        n_err        = r_err;
        n_status     = r_status;
        n_v          = r_v;
        n_out_valid  = r_out_valid;
        n_out_v0     = r_out_v0;
        n_out_v1     = r_out_v1;
        n_out_v2     = r_out_v2;
        n_out_status = r_out_status;

        // Drop the result word once taken.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && i_mode == MODE_ASSEMBLE) begin
                    n_base = acc_base[POS_W-1:0];
                    n_swap = (r_cfg.topology == TOPO_STRIP) && i_triangle_number[0];
                    n_err  = 1'b0;
                    n_step = 2'd0;
                    if (r_cfg.topology == TOPO_INVALID) begin
                        n_status = ST_TOPO;
                        n_state  = S_DONE;
                    end else if (acc_last >= {2'b00, r_cfg.index_count}) begin
                        n_status = ST_OOB;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // Issue the read of this step's element.
                if (r_step != 2'd3) begin
                    n_prev_pos = issue_pos;
                    if (issue_fetch && ({1'b0, issue_waddr} >= INDEX_WORDS_CAP)) begin
                        n_err = 1'b1;
                    end
                end
                // Finish the element read one step earlier.
                if (r_step != 2'd0) begin
                    n_v[r_step - 2'd1] = elem;
                    if (elem_oob) begin
                        n_err = 1'b1;
                    end
                end
                if (r_step == 2'd3) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then load it.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = final_status;
                    if (final_status == ST_OK) begin
                        n_out_v0 = r_v[0];
                        n_out_v1 = r_swap ? r_v[2] : r_v[1];
                        n_out_v2 = r_swap ? r_v[1] : r_v[2];
                    end else begin
                        n_out_v0 = 32'd0;
                        n_out_v1 = 32'd0;
                        n_out_v2 = 32'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_base       <= n_base;
        r_prev_pos   <= n_prev_pos;
        r_swap       <= n_swap;
        r_err        <= n_err;
        r_status     <= n_status;
        r_v          <= n_v;
        r_out_v0     <= n_out_v0;
        r_out_v1     <= n_out_v1;
        r_out_v2     <= n_out_v2;
        r_out_status <= n_out_status;
    end

    assign o_valid         = r_out_valid;
    assign o_vertex_first  = r_out_v0;
    assign o_vertex_second = r_out_v1;
    assign o_vertex_third  = r_out_v2;
    assign o_status        = r_out_status;

    // A failed triangle carries zero vertices.
    `TPA_ASSERT(a_err_zero, i_clk, i_rst_n, (o_valid && o_status != ST_OK) |-> (o_vertex_first == 32'd0 && o_vertex_second == 32'd0 && o_vertex_third == 32'd0))
    // An accepted assemble word keeps the block busy on the next cycle.
    `TPA_ASSERT(a_busy_after_tri, i_clk, i_rst_n, (accept && i_mode == MODE_ASSEMBLE) |=> !o_ready)
    // Only defined status codes leave the block.
    `TPA_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status == ST_OK || o_status == ST_OOB || o_status == ST_TOPO))
    // Invalid-topology status matches the topology register.
    `TPA_ASSERT(a_topo_status, i_clk, i_rst_n, (n_out_valid && !r_out_valid && n_out_status == ST_TOPO) |-> (r_cfg.topology == TOPO_INVALID))
    // In the idle state, outside reset, the step counter is zero or three.
    `TPA_ASSERT_ALWAYS(a_step_idle, i_clk, (r_state == S_IDLE && $past(i_rst_n) && i_rst_n) |-> (r_step == 2'd0 || r_step == 2'd3))
endmodule

// ----- sv/tpa_index_ram.sv -----
// Generic single-port RAM with registered read data.
// Holds the packed index store; no package dependency.
module tpa_index_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/tpa_elem_unit.sv -----
// Shared element unit: lane select (or position if unindexed), bound compare.
// Depends on tpa_pkg for the configuration struct and width codes.
module tpa_elem_unit (
    input  tpa_pkg::t_cfg                i_cfg,
    input  logic [31:0]                  i_word,
    input  logic [tpa_pkg::POS_W-1:0]    i_pos,
    output logic [31:0]                  o_elem,
    output logic                         o_oob
);
    import tpa_pkg::*;

    always_comb begin
        if (!i_cfg.indexed) begin
            o_elem = 32'(i_pos);
        end else begin
            case (i_cfg.index_width)
                WIDTH_BYTE: o_elem = {24'd0, i_word[8*i_pos[1:0] +: 8]};
                WIDTH_HALF: o_elem = {16'd0, i_pos[0] ? i_word[31:16] : i_word[15:0]};
                WIDTH_WORD: o_elem = i_word;
                default:    o_elem = 32'd0;
            endcase
        end
        o_oob = (o_elem >= i_cfg.vertex_count);
    end
endmodule
